// ===== rtl/core/ckms_pkg.sv =====
// shared types and codes for the capacitive key matrix scanner
// no dependencies; imported by ckms_key_store and capacitive_key_matrix_scanner
package ckms_pkg;

    localparam int unsigned POS_W  = 3;
    localparam int unsigned DIM_W  = 4;
    localparam int unsigned PER_IN_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // item kind carried on s_tuser
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_ENABLE = 3'd0,
        CFG_ROWS_IN_USE = 3'd1,
        CFG_COLS_IN_USE = 3'd2,
        CFG_SLOW_PERIOD = 3'd3
    } ckms_cfg_index_t;

    // select and drive state shown with each result
    typedef struct packed {
        logic             sample_wanted;
        logic             hys_drive;
        logic [POS_W-1:0] sel_col;
        logic [POS_W-1:0] sel_row;
    } ckms_ctl_t;

    // result beat, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]       pad;
        logic             fast_mode;
        logic             event_pressed;
        logic [POS_W-1:0] event_col;
        logic [POS_W-1:0] event_row;
        logic             event_valid;
        ckms_ctl_t        ctl;
    } ckms_result_t;

endpackage

// ===== rtl/core/capacitive_key_matrix_scanner.sv =====
// capacitive key matrix scanner, top level
// scan sequencer, pass timing and change detection around ckms_key_store
// depends on ckms_pkg and ckms_key_store
//
//  channel   | signals                                     | beat
//  ----------+---------------------------------------------+----------------------------
//  s_axis    | s_tvalid s_tready s_tdata s_tuser           | tick or sense sample
//  m_axis    | m_tvalid m_tready m_tdata m_tlast           | one result per input beat
//  cfg       | cfg_valid cfg_ready cfg_index cfg_data      | register write
//
// one input beat per cycle sustained while m_tready is high; an accepted input beat is
// registered into stage 1 and then into the output register, which presents the result
// (stage 0 sequences and issues the key store read on the input edge, stage 1 compares
// and writes back, then the output register holds the beat)
// back-to-back samples to the same key are covered by write forwarding in the store
// m_tready low holds the output register, stage 1 and then s_tready
// reset clears all keys to released at once; no clearing pass
module capacitive_key_matrix_scanner
    import ckms_pkg::*;
#(
    parameter int unsigned MAX_ROWS   = 8,
    parameter int unsigned MAX_COLS   = 8,
    parameter int unsigned TIME_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] key_level, [7:1] zero
    input  logic                  s_tuser,   // [0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [2:0] sel_row, [5:3] sel_col, [6] hys_drive,
                                             // [7] sample_wanted, [8] event_valid,
                                             // [11:9] event_row, [14:12] event_col,
                                             // [15] event_pressed, [16] fast_mode, [23:17] zero
    output logic                  m_tlast,   // pass_done
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned KEY_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned ADDR_W    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int unsigned PER_W     = (TIME_WIDTH > PER_IN_W) ? TIME_WIDTH : PER_IN_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
    localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLS);

    // configuration registers
    logic                  scan_enable_reg, scan_enable_next;
    logic [DIM_W-1:0]      rows_reg, rows_next;
    logic [DIM_W-1:0]      cols_reg, cols_next;
    logic [PER_IN_W-1:0]   slow_period_reg, slow_period_next;

    // sequencer state
    logic                  scanning_reg, scanning_next;
    logic [POS_W-1:0]      cur_row_reg, cur_row_next;
    logic [POS_W-1:0]      cur_col_reg, cur_col_next;
    logic                  last_active_reg, last_active_next;
    logic [TIME_WIDTH-1:0] pass_elapsed_reg, pass_elapsed_next;
    logic [TIME_WIDTH-1:0] wait_count_reg, wait_count_next;
    logic                  pass_changed_reg, pass_changed_next;

    // stage 1
    logic                  s1_valid_reg, s1_valid_next;
    ckms_ctl_t             s1_ctl_reg, s1_ctl_next;
    logic                  s1_access_reg, s1_access_next;
    logic                  s1_level_reg, s1_level_next;
    logic [POS_W-1:0]      s1_row_reg, s1_row_next;
    logic [POS_W-1:0]      s1_col_reg, s1_col_next;
    logic                  s1_done_reg, s1_done_next;
    logic                  s1_wfast_reg, s1_wfast_next;
    logic [TIME_WIDTH-1:0] s1_wslow_reg, s1_wslow_next;
    logic [ADDR_W-1:0]     s1_idx_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    ckms_result_t          out_reg, out_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  s1_move;
    logic                  s_accept;
    logic                  in_kind;
    logic                  in_level;
    logic [DIM_W-1:0]      rows_eff;
    logic [DIM_W-1:0]      cols_eff;
    logic [7:0]            idx_wide;
    logic [ADDR_W-1:0]     key_idx;
    logic                  rd_en;
    logic                  old_bit;
    logic                  ev;
    logic                  s1_fast;
    logic [TIME_WIDTH-1:0] s1_wait;
    logic [TIME_WIDTH-1:0] wait_eff;
    logic [TIME_WIDTH-1:0] wait_dec;
    logic [PER_W-1:0]      slow_ext;
    logic [TIME_WIDTH-1:0] period;
    logic                  cfg_we;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign in_kind  = s_tuser;
    assign in_level = s_tdata[0];
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // live clamp of the matrix size
    always_comb
    begin
        priority if (rows_reg == '0)
            rows_eff = DIM_W'(1);
        else if (rows_reg > ROWS_MAX)
            rows_eff = ROWS_MAX;
        else
            rows_eff = rows_reg;
        priority if (cols_reg == '0)
            cols_eff = DIM_W'(1);
        else if (cols_reg > COLS_MAX)
            cols_eff = COLS_MAX;
        else
            cols_eff = cols_reg;
    end

    // key index row * cols + col, always below the depth
    assign idx_wide = 8'(cur_row_reg) * 8'(cols_eff) + 8'(cur_col_reg);
    assign key_idx  = idx_wide[ADDR_W-1:0];
    assign rd_en    = s_accept && (in_kind == KIND_SAMPLE) && scanning_reg;

    ckms_key_store #(
        .DEPTH  (KEY_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (key_idx),
        .wr_en   (s1_move && s1_access_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_level_reg),
        .rd_data (old_bit)
    );

    // address of the key in stage 1, kept for the write back
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_idx_reg <= key_idx;
        end
    end

    // change detection and the interval chosen at pass end
    assign ev      = s1_access_reg && (old_bit != s1_level_reg);
    assign s1_fast = pass_changed_reg || ev;
    assign s1_wait = s1_fast ? TIME_WIDTH'(s1_wfast_reg) : s1_wslow_reg;
    // a pass ending in stage 1 hands its wait count straight to a tick in stage 0
    assign wait_eff = (s1_valid_reg && s1_done_reg) ? s1_wait : wait_count_reg;
    assign wait_dec = (wait_eff != '0) ? (wait_eff - TIME_WIDTH'(1)) : '0;

    // slow period saturated to the time counter range
    assign slow_ext = PER_W'(slow_period_reg);
    assign period   = (slow_ext > PER_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(slow_ext);

    always_comb
    begin
        scan_enable_next  = scan_enable_reg;
        rows_next         = rows_reg;
        cols_next         = cols_reg;
        slow_period_next  = slow_period_reg;
        scanning_next     = scanning_reg;
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        last_active_next  = last_active_reg;
        pass_elapsed_next = pass_elapsed_reg;
        wait_count_next   = wait_count_reg;
        pass_changed_next = pass_changed_reg;
        s1_valid_next     = s1_valid_reg;
        s1_ctl_next       = s1_ctl_reg;
        s1_access_next    = s1_access_reg;
        s1_level_next     = s1_level_reg;
        s1_row_next       = s1_row_reg;
        s1_col_next       = s1_col_reg;
        s1_done_next      = s1_done_reg;
        s1_wfast_next     = s1_wfast_reg;
        s1_wslow_next     = s1_wslow_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        out_last_next     = out_last_reg;

        // stage 1 retires into the output register
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_move)
        begin
            out_next.pad           = '0;
            out_next.ctl           = s1_ctl_reg;
            out_next.event_valid   = ev;
            out_next.event_row     = ev ? s1_row_reg : '0;
            out_next.event_col     = ev ? s1_col_reg : '0;
            out_next.event_pressed = ev & s1_level_reg;
            out_next.fast_mode     = s1_done_reg & s1_fast;
            out_last_next          = s1_done_reg;
            if (ev)
            begin
                pass_changed_next = 1'b1;
            end
            if (s1_done_reg)
            begin
                wait_count_next = s1_wait;
            end
        end

        // stage 0: sequencing on the accepted beat
        if (s_tready)
        begin
            s1_valid_next = s_accept;
        end
        if (s_accept)
        begin
            s1_access_next = 1'b0;
            s1_level_next  = in_level;
            s1_row_next    = cur_row_reg;
            s1_col_next    = cur_col_reg;
            s1_done_next   = 1'b0;
            s1_wfast_next  = (pass_elapsed_reg == '0);
            s1_wslow_next  = (pass_elapsed_reg >= period) ? '0 : (period - pass_elapsed_reg);
            if (in_kind == KIND_TICK)
            begin
                if (scanning_reg)
                begin
                    if (pass_elapsed_reg != TIME_MAX)
                    begin
                        pass_elapsed_next = pass_elapsed_reg + TIME_WIDTH'(1);
                    end
                end
                else if (scan_enable_reg)
                begin
                    wait_count_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        // pass start
                        scanning_next     = 1'b1;
                        cur_row_next      = '0;
                        cur_col_next      = '0;
                        last_active_next  = 1'b0;
                        pass_elapsed_next = '0;
                        pass_changed_next = 1'b0;
                    end
                end
            end
            else if (scanning_reg)
            begin
                s1_access_next   = 1'b1;
                last_active_next = in_level;
                if ((DIM_W'(cur_col_reg) + DIM_W'(1)) < cols_eff)
                begin
                    cur_col_next = cur_col_reg + POS_W'(1);
                end
                else if ((DIM_W'(cur_row_reg) + DIM_W'(1)) < rows_eff)
                begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + POS_W'(1);
                end
                else
                begin
                    // last position: pass end
                    s1_done_next     = 1'b1;
                    scanning_next    = 1'b0;
                    cur_row_next     = '0;
                    cur_col_next     = '0;
                    last_active_next = 1'b0;
                end
            end
            s1_ctl_next.sample_wanted = scanning_next;
            s1_ctl_next.hys_drive     = scanning_next & last_active_next;
            s1_ctl_next.sel_row       = scanning_next ? cur_row_next : '0;
            s1_ctl_next.sel_col       = scanning_next ? cur_col_next : '0;
        end

        // register writes must be made only while idle; the block itself does not enforce it
        if (cfg_we)
        begin
            unique case (ckms_cfg_index_t'(cfg_index))
                CFG_SCAN_ENABLE:
                begin
                    if (cfg_data[0] && !scan_enable_reg)
                    begin
                        wait_count_next = '0;
                    end
                    scan_enable_next = cfg_data[0];
                end
                CFG_ROWS_IN_USE: rows_next = cfg_data[DIM_W-1:0];
                CFG_COLS_IN_USE: cols_next = cfg_data[DIM_W-1:0];
                CFG_SLOW_PERIOD: slow_period_next = cfg_data[PER_IN_W-1:0];
                default:         scan_enable_next = scan_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg  <= 1'b0;
            rows_reg         <= DIM_W'(8);
            cols_reg         <= DIM_W'(8);
            slow_period_reg  <= PER_IN_W'(10);
            scanning_reg     <= 1'b0;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            last_active_reg  <= 1'b0;
            pass_elapsed_reg <= '0;
            wait_count_reg   <= '0;
            pass_changed_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_access_reg    <= 1'b0;
            s1_done_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            scan_enable_reg  <= scan_enable_next;
            rows_reg         <= rows_next;
            cols_reg         <= cols_next;
            slow_period_reg  <= slow_period_next;
            scanning_reg     <= scanning_next;
            cur_row_reg      <= cur_row_next;
            cur_col_reg      <= cur_col_next;
            last_active_reg  <= last_active_next;
            pass_elapsed_reg <= pass_elapsed_next;
            wait_count_reg   <= wait_count_next;
            pass_changed_reg <= pass_changed_next;
            s1_valid_reg     <= s1_valid_next;
            s1_access_reg    <= s1_access_next;
            s1_done_reg      <= s1_done_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_ctl_reg   <= s1_ctl_next;
        s1_level_reg <= s1_level_next;
        s1_row_reg   <= s1_row_next;
        s1_col_reg   <= s1_col_next;
        s1_wfast_reg <= s1_wfast_next;
        s1_wslow_reg <= s1_wslow_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/ckms_key_store.sv =====
// one bit per key, synchronous read with registered read data
// cleared by reset through per-entry valid flags; forwards the last write
// depends on ckms_pkg
module ckms_key_store
    import ckms_pkg::*;
#(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    output logic              rd_data
);

    logic              key_mem [DEPTH];
    logic              rd_bit_reg;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [DEPTH-1:0]  entry_vld_reg;
    logic              fwd_vld_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic              fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_bit_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_addr_reg   <= '0;
            fwd_vld_reg   <= 1'b0;
            fwd_addr_reg  <= '0;
            fwd_data_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg  <= entry_vld_reg[rd_addr];
                rd_addr_reg <= rd_addr;
            end
            if (wr_en)
            begin
                entry_vld_reg[wr_addr] <= 1'b1;
                fwd_vld_reg  <= 1'b1;
                fwd_addr_reg <= wr_addr;
                fwd_data_reg <= wr_data;
            end
        end
    end

    // a write on the read edge is not in the array read yet
    assign rd_data = (fwd_vld_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                    : (rd_vld_reg & rd_bit_reg);

endmodule
